// File: rtl/core/hhtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhtd_pkg
// Shared types and constants of the timed heading-hold drive core.
// ----------------------------------------------------------------------------
package hhtd_pkg;

  // Field widths.
  localparam int unsigned YAW_W     = 16;
  localparam int unsigned SPEED_W   = 10;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned RATE_W    = 10;
  localparam int unsigned DB_W      = 15;
  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned TIME_W    = 32;

  // Drive constants.
  localparam logic [TIME_W-1:0]  TICK_MS     = 32'd10;
  localparam logic [SPEED_W-1:0] SPEED_LIMIT = 10'd999;

  // Run time division: distance * 1e6 / (speed * rate), one quotient bit a cycle.
  localparam int unsigned NUM_W     = 36;
  localparam int unsigned DIV_W     = 20;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [NUM_W-1:0]     SCALE         = 36'd1000000;
  localparam logic [DIV_W-1:0]     ZERO_RATE_DIV = 20'd1000;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS     = 6'd36;

  // Heading error and correction.
  localparam int unsigned ERR_W   = 18;
  localparam int unsigned MAG_W   = 15;
  localparam int unsigned PROD_W  = 23;
  localparam int unsigned RECIP_W = 18;
  localparam int unsigned Q0_W    = 17;
  localparam int unsigned REM_W   = 24;
  localparam logic signed [ERR_W-1:0] WRAP_LIM  = 18'sd18000;
  localparam logic signed [ERR_W-1:0] WRAP_SPAN = 18'sd36000;
  // floor(2^24 / 100); the estimate is at most one below the true quotient.
  localparam logic [RECIP_W-1:0] RECIP       = 18'd167772;
  localparam int unsigned        RECIP_SHIFT = 24;
  localparam logic [REM_W-1:0]   HUNDRED     = 24'd100;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_SPEED      = 3'd0,
    REG_TARGET_DISTANCE = 3'd1,
    REG_RATE_MILLI      = 3'd2,
    REG_DEADBAND        = 3'd3,
    REG_GAIN            = 3'd4,
    REG_MAX_CORRECTION  = 3'd5
  } cfg_reg_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_REJECTED = 3'd0,
    STAT_STARTED  = 3'd1,
    STAT_DRIVING  = 3'd2,
    STAT_STOPPED  = 3'd3,
    STAT_IDLE     = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_START,
    S_DIV,
    S_COMMIT,
    S_TICK,
    S_MUL1,
    S_MUL2,
    S_FIN,
    S_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_load;
    logic set_reject;
    logic prep_div;
    logic div_step;
    logic commit;
    logic set_idle;
    logic set_stop;
    logic wrap;
    logic mul1;
    logic mul2;
    logic fin;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_tick;
    logic reject;
    logic running;
    logic time_up;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/heading_hold_timed_drive_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_hold_timed_drive_core
// Timed straight drive with proportional heading hold and deadband.
// ----------------------------------------------------------------------------
// One item is in work at a time and each gives exactly one result. A tick
// goes through dispatch, the tick test, two multiply steps and the finish step
// to its result; an idle tick or a stop goes from the tick test to the result.
// An accepted start runs the run time divider, which retires one quotient bit
// per cycle over 36 steps, then commits; a rejected start ends at the start test.
// The input is ready again in the cycle after the result is loaded, and a loaded
// result may wait for the sink while the next item is taken and worked on.
module heading_hold_timed_drive_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // [15:0] yaw_raw
  input  logic [0:0]                       s_axis_tuser,  // [0] operation
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // [9:0] left_cmd,
                                                          // [19:10] right_cmd
  output logic [2:0]                       m_axis_tuser,  // [2:0] status
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [hhtd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hhtd_pkg::CFG_W-1:0]       cfg_data_i
);
  import hhtd_pkg::*;

  cmd_t               cmd;
  dp_status_t         dp_stat;
  logic [SPEED_W-1:0] left;
  logic [SPEED_W-1:0] right;

  // Sequencer.
  hhtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (cmd)
  );

  // Datapath.
  hhtd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_op_i      (s_axis_tuser[0]),
    .in_yaw_i     (s_axis_tdata),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_left_o   (left),
    .out_right_o  (right),
    .cmd_i        (cmd),
    .stat_o       (dp_stat)
  );

  assign m_axis_tdata = {4'b0000, right, left};

`ifndef SYNTHESIS
  // Only a driving result carries nonzero wheel speeds.
  a_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STAT_DRIVING) |-> (m_axis_tdata == '0))
    else $error("wheel speed nonzero outside a driving result");

  // Wheel commands never exceed the speed limit.
  a_speed_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (left <= SPEED_LIMIT) && (right <= SPEED_LIMIT))
    else $error("wheel speed above limit");

  // One item at a time: input is not ready right after a transfer.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // A new result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");
`endif

endmodule

// File: rtl/core/hhtd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhtd_ctrl
// Sequencer of the drive core: walks one item through the datapath steps.
// ----------------------------------------------------------------------------
module hhtd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hhtd_pkg::dp_status_t stat_i,
  output hhtd_pkg::cmd_t      cmd_o
);
  import hhtd_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: state_d = stat_i.op_tick ? S_TICK : S_START;
      S_START:    state_d = stat_i.reject ? S_DONE : S_DIV;
      S_DIV:      if (stat_i.div_last) state_d = S_COMMIT;
      S_COMMIT:   state_d = S_DONE;
      S_TICK: begin
        if (!stat_i.running || stat_i.time_up) begin
          state_d = S_DONE;
        end else begin
          state_d = S_MUL1;
        end
      end
      S_MUL1:     state_d = S_MUL2;
      S_MUL2:     state_d = S_FIN;
      S_FIN:      state_d = S_DONE;
      S_DONE:     if (stat_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.in_load  = in_valid_i;
      end
      S_DISPATCH: ;
      S_START: begin
        cmd_o.set_reject = stat_i.reject;
        cmd_o.prep_div   = !stat_i.reject;
      end
      S_DIV:    cmd_o.div_step = 1'b1;
      S_COMMIT: cmd_o.commit = 1'b1;
      S_TICK: begin
        cmd_o.set_idle = !stat_i.running;
        cmd_o.set_stop = stat_i.running && stat_i.time_up;
        cmd_o.wrap     = stat_i.running && !stat_i.time_up;
      end
      S_MUL1:   cmd_o.mul1 = 1'b1;
      S_MUL2:   cmd_o.mul2 = 1'b1;
      S_FIN:    cmd_o.fin = 1'b1;
      S_DONE:   cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/hhtd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhtd_dp
// Datapath of the drive core: configuration, run state, run time divider,
// heading correction and the output register.
// ----------------------------------------------------------------------------
module hhtd_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hhtd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hhtd_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_op_i,
  input  logic [hhtd_pkg::YAW_W-1:0]        in_yaw_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [hhtd_pkg::STATUS_W-1:0]     out_status_o,
  output logic [hhtd_pkg::SPEED_W-1:0]      out_left_o,
  output logic [hhtd_pkg::SPEED_W-1:0]      out_right_o,
  input  hhtd_pkg::cmd_t                    cmd_i,
  output hhtd_pkg::dp_status_t              stat_o
);
  import hhtd_pkg::*;

  // Configuration registers.
  logic [SPEED_W-1:0] base_q;
  logic [DIST_W-1:0]  dist_q;
  logic [RATE_W-1:0]  rate_q;
  logic [DB_W-1:0]    db_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [SPEED_W-1:0] maxc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 10'd300;
      dist_q <= 16'd0;
      rate_q <= 10'd60;
      db_q   <= 15'd200;
      gain_q <= 8'd12;
      maxc_q <= 10'd150;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE_SPEED:      base_q <= cfg_data_i[SPEED_W-1:0];
        REG_TARGET_DISTANCE: dist_q <= cfg_data_i[DIST_W-1:0];
        REG_RATE_MILLI:      rate_q <= cfg_data_i[RATE_W-1:0];
        REG_DEADBAND:        db_q   <= cfg_data_i[DB_W-1:0];
        REG_GAIN:            gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_MAX_CORRECTION:  maxc_q <= cfg_data_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured input item.
  logic             op_q;
  logic [YAW_W-1:0] yaw_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q  <= in_op_i;
      yaw_q <= in_yaw_i;
    end
  end

  // Run state.
  logic              running_q;
  logic [YAW_W-1:0]  held_q;
  logic [TIME_W-1:0] run_q;
  logic [TIME_W-1:0] elapsed_q;

  // Divider registers: the dividend shifts out at the top while quotient bits
  // shift in at the bottom.
  logic [NUM_W-1:0]     num_q;
  logic [DIV_W-1:0]     div_q;
  logic [DIV_W-1:0]     rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  // Correction pipeline registers.
  logic signed [ERR_W-1:0]   err_q;
  logic                      pos_q;
  logic                      neg_q;
  logic [PROD_W-1:0]         prod1_q;
  logic [PROD_W+RECIP_W-1:0] prod2_q;

  // Result held until the output register is free.
  status_e            res_status_q;
  logic [SPEED_W-1:0] res_left_q;
  logic [SPEED_W-1:0] res_right_q;

  // Start setup: numerator and divisor products.
  logic [DIV_W-1:0] speed_rate;
  assign speed_rate = DIV_W'(base_q) * DIV_W'(rate_q);

  // One restoring division step.
  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] rem_sub;
  logic           q_bit;
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign q_bit   = rem_sh >= {1'b0, div_q};

  // Heading error wrapped once into the half turn.
  logic signed [ERR_W-1:0] err_raw;
  logic signed [ERR_W-1:0] err_w1;
  logic signed [ERR_W-1:0] err_w2;
  assign err_raw = ERR_W'($signed(yaw_q)) - ERR_W'($signed(held_q));
  assign err_w1  = (err_raw > WRAP_LIM) ? err_raw - WRAP_SPAN : err_raw;
  assign err_w2  = (err_w1 < -WRAP_LIM) ? err_w1 + WRAP_SPAN : err_w1;

  // Deadband test and error magnitude.
  logic signed [ERR_W-1:0] db_s;
  logic signed [ERR_W-1:0] err_neg;
  logic                    pos_hit;
  logic                    neg_hit;
  logic [MAG_W-1:0]        mag;
  assign db_s    = $signed({3'b000, db_q});
  assign err_neg = -err_q;
  assign pos_hit = err_q > db_s;
  assign neg_hit = err_q < -db_s;
  assign mag     = pos_hit ? err_q[MAG_W-1:0] : err_neg[MAG_W-1:0];

  // Divide by one hundred: reciprocal estimate plus one correction step.
  logic [Q0_W-1:0]    q0;
  logic [REM_W-1:0]   q0_x100;
  logic [REM_W-1:0]   q0_rem;
  logic [Q0_W-1:0]    corr_full;
  logic [SPEED_W-1:0] corr;
  logic [SPEED_W:0]   left_sum;
  logic [SPEED_W:0]   right_sum;
  logic [SPEED_W-1:0] left_sat;
  logic [SPEED_W-1:0] right_sat;
  assign q0        = prod2_q[RECIP_SHIFT +: Q0_W];
  assign q0_x100   = REM_W'(q0) * HUNDRED;
  assign q0_rem    = REM_W'(prod1_q) - q0_x100;
  assign corr_full = (q0_rem >= HUNDRED) ? q0 + Q0_W'(1) : q0;
  assign corr      = (corr_full > Q0_W'(maxc_q)) ? maxc_q : corr_full[SPEED_W-1:0];
  assign left_sum  = (SPEED_W+1)'(base_q) + (pos_q ? (SPEED_W+1)'(corr) : '0);
  assign right_sum = (SPEED_W+1)'(base_q) + (neg_q ? (SPEED_W+1)'(corr) : '0);
  assign left_sat  = (left_sum > (SPEED_W+1)'(SPEED_LIMIT)) ? SPEED_LIMIT
                                                            : left_sum[SPEED_W-1:0];
  assign right_sat = (right_sum > (SPEED_W+1)'(SPEED_LIMIT)) ? SPEED_LIMIT
                                                             : right_sum[SPEED_W-1:0];

  // Run state: updated on commit, stop and drive steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      held_q    <= '0;
      run_q     <= '0;
      elapsed_q <= '0;
    end else if (cmd_i.commit) begin
      running_q <= 1'b1;
      held_q    <= yaw_q;
      run_q     <= (|num_q[NUM_W-1:TIME_W]) ? '1 : num_q[TIME_W-1:0];
      elapsed_q <= '0;
    end else if (cmd_i.set_stop) begin
      running_q <= 1'b0;
    end else if (cmd_i.fin) begin
      elapsed_q <= (elapsed_q > ('1 - TICK_MS)) ? '1 : elapsed_q + TICK_MS;
    end
  end

  // Divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.prep_div) begin
      cnt_q <= DIV_STEPS;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep_div) begin
      num_q <= NUM_W'(dist_q) * SCALE;
      div_q <= (speed_rate == '0) ? ZERO_RATE_DIV : speed_rate;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NUM_W-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

  // Correction pipeline.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wrap) begin
      err_q <= err_w2;
    end
    if (cmd_i.mul1) begin
      pos_q   <= pos_hit;
      neg_q   <= neg_hit;
      prod1_q <= PROD_W'(mag) * PROD_W'(gain_q);
    end
    if (cmd_i.mul2) begin
      prod2_q <= (PROD_W+RECIP_W)'(prod1_q) * (PROD_W+RECIP_W)'(RECIP);
    end
  end

  // Result staging.
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_reject) begin
      res_status_q <= STAT_REJECTED;
      res_left_q   <= '0;
      res_right_q  <= '0;
    end else if (cmd_i.commit) begin
      res_status_q <= STAT_STARTED;
      res_left_q   <= '0;
      res_right_q  <= '0;
    end else if (cmd_i.set_idle) begin
      res_status_q <= STAT_IDLE;
      res_left_q   <= '0;
      res_right_q  <= '0;
    end else if (cmd_i.set_stop) begin
      res_status_q <= STAT_STOPPED;
      res_left_q   <= '0;
      res_right_q  <= '0;
    end else if (cmd_i.fin) begin
      res_status_q <= STAT_DRIVING;
      res_left_q   <= left_sat;
      res_right_q  <= right_sat;
    end
  end

  // Output register.
  logic               out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SPEED_W-1:0] out_left_q;
  logic [SPEED_W-1:0] out_right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_left_q   <= res_left_q;
      out_right_q  <= res_right_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_left_o   = out_left_q;
  assign out_right_o  = out_right_q;

  // Status to the controller.
  assign stat_o.op_tick  = op_q;
  assign stat_o.reject   = (base_q == '0) || (dist_q == '0);
  assign stat_o.running  = running_q;
  assign stat_o.time_up  = elapsed_q >= run_q;
  assign stat_o.div_last = cnt_q == DIV_CNT_W'(1);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule
